/* rtl/vrtc_pkg.sv */
// Shared types, codes, constants and trig helpers for the vertex rotate/translate block.
package vrtc_pkg;

  typedef logic [2:0][31:0] vec_t;

  typedef enum logic [1:0] {
    FN_CLEAR     = 2'd0,
    FN_LOAD      = 2'd1,
    FN_TRANSLATE = 2'd2,
    FN_ROTATE    = 2'd3
  } func_e;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic CFG_SHIFT_STEP = 1'b0;
  localparam logic CFG_ANGLE_STEP = 1'b1;

  localparam logic [15:0] SHIFT_STEP_RST = 16'd3277;
  localparam logic [4:0]  ANGLE_STEP_RST = 5'd3;

  localparam logic [31:0] COORD_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] COORD_MIN = 32'h8000_0000;

  localparam int DEG_QUARTER = 90;
  localparam int DEG_HALF    = 180;
  localparam int DEG_3QUART  = 270;
  localparam int DEG_FULL    = 360;
  localparam int ANG_OFFSET  = 22 * DEG_FULL;
  localparam int RECIP_360   = 2912;
  localparam int RECIP_SHIFT = 20;
  localparam int TRIG_FRAC   = 14;

  localparam logic signed [36:0] SAT_HI = 37'sd2147483647;
  localparam logic signed [36:0] SAT_LO = -37'sd2147483648;

  typedef struct packed {
    logic               rot;
    logic [1:0]         axis;
    logic               set;
    logic [4:0]         idx;
    logic signed [13:0] ang;
    logic signed [24:0] trans;
    vec_t               cen;
  } s1_t;

  localparam logic [14:0] SIN_TAB [91] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
    15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
    15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
    15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
    15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
    15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
    15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
    15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  function automatic logic signed [15:0] sin_deg(input logic [8:0] d);
    logic [8:0]         k;
    logic               neg;
    logic signed [15:0] mag;
    if (d <= 9'(DEG_QUARTER)) begin
      k   = d;
      neg = 1'b0;
    end else if (d <= 9'(DEG_HALF)) begin
      k   = 9'(DEG_HALF) - d;
      neg = 1'b0;
    end else if (d <= 9'(DEG_3QUART)) begin
      k   = d - 9'(DEG_HALF);
      neg = 1'b1;
    end else begin
      k   = 9'(DEG_FULL) - d;
      neg = 1'b1;
    end
    mag = $signed({1'b0, SIN_TAB[k[6:0]]});
    return neg ? -mag : mag;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [36:0] v);
    logic [31:0] r;
    if (v > SAT_HI) begin
      r = COORD_MAX;
    end else if (v < SAT_LO) begin
      r = COORD_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/vertex_rotate_translate_about_center.sv */
// Top level: rotate or translate stored vertices about the cage bounding-box centre.
// Throughput: one beat per cycle; all stages advance together, stall only on out_ready_i.
// Registers in order: input/read, angle and translate, trig, product, result.
// Reset clears pipeline valids, empties the bounding box and restores register defaults.
// The position store is not cleared; no clearing pass is needed.
module vertex_rotate_translate_about_center import vrtc_pkg::*; #(
  parameter int VERTS_PER_SET = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         func_i,
  input  logic               vertex_set_i,
  input  logic [4:0]         vertex_index_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  input  logic [1:0]         axis_i,
  input  logic signed [7:0]  slider_pos_i,
  input  logic signed [7:0]  slider_ref_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic               out_set_o,
  output logic [4:0]         out_index_o
);

  localparam int Depth = 2 * VERTS_PER_SET;
  localparam int AW    = $clog2(Depth);

  logic [15:0] shift_step_q;
  logic [4:0]  angle_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_step_q <= SHIFT_STEP_RST;
      angle_step_q <= ANGLE_STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SHIFT_STEP: shift_step_q <= cfg_wdata_i;
        CFG_ANGLE_STEP: angle_step_q <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  logic               en, accept, in_range;
  func_e              fn;
  logic [AW-1:0]      addr;
  logic               wr, clr;
  vec_t               coords, cen, vtx, out_vec;
  logic signed [8:0]  diff;
  logic signed [14:0] ang_full;
  logic signed [25:0] trans_full;
  s1_t                s1_q, s1_d;
  logic               s1_valid_q, s1_valid_d;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;
  assign accept     = in_valid_i && en;
  assign fn         = func_e'(func_i);
  assign in_range   = 32'(vertex_index_i) < VERTS_PER_SET;
  assign addr       = vertex_set_i ? AW'(VERTS_PER_SET) + AW'(vertex_index_i)
                                   : AW'(vertex_index_i);
  assign wr         = accept && (fn == FN_LOAD) && in_range;
  assign clr        = accept && (fn == FN_CLEAR);
  assign coords     = {coord_z_i, coord_y_i, coord_x_i};

  assign diff = $signed({slider_pos_i[7], slider_pos_i})
              - $signed({slider_ref_i[7], slider_ref_i});
  assign ang_full   = $signed({1'b0, angle_step_q}) * diff;
  assign trans_full = $signed({1'b0, shift_step_q}) * diff;

  always_comb begin
    s1_valid_d  = accept && in_range && ((fn == FN_TRANSLATE) || (fn == FN_ROTATE));
    s1_d.rot    = (fn == FN_ROTATE);
    s1_d.axis   = axis_i;
    s1_d.set    = vertex_set_i;
    s1_d.idx    = vertex_index_i;
    s1_d.ang    = ang_full[13:0];
    s1_d.trans  = trans_full[24:0];
    s1_d.cen    = cen;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
    end
  end

  vrtc_pos_ram #(
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr),
    .waddr_i (addr),
    .wdata_i (coords),
    .re_i    (en),
    .raddr_i (addr),
    .rdata_o (vtx)
  );

  vrtc_bbox u_bbox (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (clr),
    .upd_i  (wr && vertex_set_i),
    .pt_i   (coords),
    .cen_o  (cen)
  );

  vrtc_xform u_xform (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .s1_valid_i  (s1_valid_q),
    .s1_i        (s1_q),
    .vtx_i       (vtx),
    .out_valid_o (out_valid_o),
    .out_vec_o   (out_vec),
    .out_set_o   (out_set_o),
    .out_index_o (out_index_o)
  );

  assign out_x_o = out_vec[0];
  assign out_y_o = out_vec[1];
  assign out_z_o = out_vec[2];

endmodule

/* rtl/vrtc_pos_ram.sv */
// Initial position store: one write port, one registered read port.
module vrtc_pos_ram import vrtc_pkg::*; #(
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  vec_t                     wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output vec_t                     rdata_o
);

  vec_t mem [Depth];
  vec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/vrtc_bbox.sv */
// Running bounding box of the cage vertices and its centre.
module vrtc_bbox import vrtc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic clr_i,
  input  logic upd_i,
  input  vec_t pt_i,
  output vec_t cen_o
);

  vec_t min_q, min_d;
  vec_t max_q, max_d;
  logic signed [32:0] sum;

  always_comb begin
    min_d = min_q;
    max_d = max_q;
    if (clr_i) begin
      min_d = {3{COORD_MAX}};
      max_d = {3{COORD_MIN}};
    end else if (upd_i) begin
      for (int k = 0; k < 3; k++) begin
        if ($signed(pt_i[k]) < $signed(min_q[k])) begin
          min_d[k] = pt_i[k];
        end
        if ($signed(pt_i[k]) > $signed(max_q[k])) begin
          max_d[k] = pt_i[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= {3{COORD_MAX}};
      max_q <= {3{COORD_MIN}};
    end else begin
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  // empty box gives a zero centre
  always_comb begin
    cen_o = '0;
    sum   = '0;
    for (int k = 0; k < 3; k++) begin
      sum = $signed({min_q[k][31], min_q[k]}) + $signed({max_q[k][31], max_q[k]});
      if ($signed(min_q[k]) <= $signed(max_q[k])) begin
        cen_o[k] = sum[32:1];
      end
    end
  end

endmodule

/* rtl/vrtc_xform.sv */
// Transform pipeline: angle reduction, sine/cosine, products, sums and result register.
module vrtc_xform import vrtc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       s1_valid_i,
  input  s1_t        s1_i,
  input  vec_t       vtx_i,
  output logic       out_valid_o,
  output vec_t       out_vec_o,
  output logic       out_set_o,
  output logic [4:0] out_index_o
);

  typedef struct packed {
    logic             rot;
    logic [1:0]       axis;
    logic [13:0]      ang_u;
    logic [5:0]       quo;
    logic [2:0][32:0] p;
    vec_t             cen;
    vec_t             tv;
    logic             set;
    logic [4:0]       idx;
  } s2_t;

  typedef struct packed {
    logic               rot_en;
    logic [1:0]         a;
    logic [1:0]         b;
    logic signed [32:0] pa;
    logic signed [32:0] pb;
    logic signed [31:0] ca;
    logic signed [31:0] cb;
    logic signed [15:0] sn;
    logic signed [15:0] cs;
    vec_t               tv;
    logic               set;
    logic [4:0]         idx;
  } s3_t;

  typedef struct packed {
    logic               rot_en;
    logic [1:0]         a;
    logic [1:0]         b;
    logic signed [48:0] m_ac;
    logic signed [48:0] m_bs;
    logic signed [48:0] m_as;
    logic signed [48:0] m_bc;
    logic signed [31:0] ca;
    logic signed [31:0] cb;
    vec_t               tv;
    logic               set;
    logic [4:0]         idx;
  } s4_t;

  s2_t  s2_q, s2_d;
  s3_t  s3_q, s3_d;
  s4_t  s4_q, s4_d;
  logic s2_valid_q, s3_valid_q, s4_valid_q, out_valid_q;
  vec_t out_vec_q, out_vec_d;
  logic out_set_q;
  logic [4:0] out_index_q;

  logic [14:0]        ang_sum;
  logic [25:0]        quo_full;
  logic signed [32:0] tsum;
  logic signed [32:0] tadd;

  // reduce angle, relative positions, translation
  always_comb begin
    ang_sum  = {s1_i.ang[13], s1_i.ang} + 15'(ANG_OFFSET);
    s2_d.rot = s1_i.rot;
    s2_d.axis  = s1_i.axis;
    s2_d.ang_u = ang_sum[13:0];
    quo_full   = 26'(ang_sum[13:0]) * 26'(RECIP_360);
    s2_d.quo   = quo_full[RECIP_SHIFT +: 6];
    s2_d.cen   = s1_i.cen;
    s2_d.set   = s1_i.set;
    s2_d.idx   = s1_i.idx;
    s2_d.p     = '0;
    s2_d.tv    = '0;
    tsum       = '0;
    tadd       = '0;
    for (int k = 0; k < 3; k++) begin
      s2_d.p[k] = $signed({vtx_i[k][31], vtx_i[k]})
                - $signed({s1_i.cen[k][31], s1_i.cen[k]});
      tadd = (!s1_i.rot && (s1_i.axis == 2'(k)))
           ? $signed({{8{s1_i.trans[24]}}, s1_i.trans}) : 33'sd0;
      tsum = $signed({vtx_i[k][31], vtx_i[k]}) + tadd;
      s2_d.tv[k] = sat32({{4{tsum[32]}}, tsum});
    end
  end

  logic [14:0] r0;
  logic [8:0]  deg;
  logic [9:0]  cdeg_sum;
  logic [8:0]  cdeg;

  // finish modulo, look up sine and cosine, pick the rotated plane
  always_comb begin
    r0 = 15'(s2_q.ang_u) - 15'(s2_q.quo) * 15'(DEG_FULL);
    if (r0 >= 15'(DEG_FULL)) begin
      deg = 9'(r0 - 15'(DEG_FULL));
    end else begin
      deg = 9'(r0);
    end
    cdeg_sum = 10'(deg) + 10'(DEG_QUARTER);
    if (cdeg_sum >= 10'(DEG_FULL)) begin
      cdeg = 9'(cdeg_sum - 10'(DEG_FULL));
    end else begin
      cdeg = 9'(cdeg_sum);
    end
    s3_d.rot_en = s2_q.rot && (s2_q.axis != 2'd3);
    case (s2_q.axis)
      AXIS_X: begin
        s3_d.a = 2'd1;
        s3_d.b = 2'd2;
      end
      AXIS_Y: begin
        s3_d.a = 2'd2;
        s3_d.b = 2'd0;
      end
      AXIS_Z: begin
        s3_d.a = 2'd0;
        s3_d.b = 2'd1;
      end
      default: begin
        s3_d.a = 2'd0;
        s3_d.b = 2'd1;
      end
    endcase
    s3_d.pa  = $signed(s2_q.p[s3_d.a]);
    s3_d.pb  = $signed(s2_q.p[s3_d.b]);
    s3_d.ca  = $signed(s2_q.cen[s3_d.a]);
    s3_d.cb  = $signed(s2_q.cen[s3_d.b]);
    s3_d.sn  = sin_deg(deg);
    s3_d.cs  = sin_deg(cdeg);
    s3_d.tv  = s2_q.tv;
    s3_d.set = s2_q.set;
    s3_d.idx = s2_q.idx;
  end

  always_comb begin
    s4_d.rot_en = s3_q.rot_en;
    s4_d.a      = s3_q.a;
    s4_d.b      = s3_q.b;
    s4_d.m_ac   = s3_q.pa * s3_q.cs;
    s4_d.m_bs   = s3_q.pb * s3_q.sn;
    s4_d.m_as   = s3_q.pa * s3_q.sn;
    s4_d.m_bc   = s3_q.pb * s3_q.cs;
    s4_d.ca     = s3_q.ca;
    s4_d.cb     = s3_q.cb;
    s4_d.tv     = s3_q.tv;
    s4_d.set    = s3_q.set;
    s4_d.idx    = s3_q.idx;
  end

  logic signed [49:0] sa, sb;
  logic signed [36:0] ra, rb;

  always_comb begin
    sa = $signed({s4_q.m_ac[48], s4_q.m_ac}) - $signed({s4_q.m_bs[48], s4_q.m_bs});
    sb = $signed({s4_q.m_as[48], s4_q.m_as}) + $signed({s4_q.m_bc[48], s4_q.m_bc});
    ra = $signed({{5{s4_q.ca[31]}}, s4_q.ca}) + $signed({sa[49], sa[49:TRIG_FRAC]});
    rb = $signed({{5{s4_q.cb[31]}}, s4_q.cb}) + $signed({sb[49], sb[49:TRIG_FRAC]});
    out_vec_d = s4_q.tv;
    if (s4_q.rot_en) begin
      out_vec_d[s4_q.a] = sat32(ra);
      out_vec_d[s4_q.b] = sat32(rb);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      s2_valid_q  <= s1_valid_i;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q;
    end
  end

  // hold every stage while the result waits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q        <= s2_d;
      s3_q        <= s3_d;
      s4_q        <= s4_d;
      out_vec_q   <= out_vec_d;
      out_set_q   <= s4_q.set;
      out_index_q <= s4_q.idx;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_vec_o   = out_vec_q;
  assign out_set_o   = out_set_q;
  assign out_index_o = out_index_q;

endmodule
